@@ rtl/core/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, defaults and status codes of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

   // Coefficient and root width, fixed by the request format.
   localparam int COEF_W = 32;

   // Default number of fraction bits in the coefficients and roots.
   localparam int FRAC_BITS_DEF = 16;

   // Discriminant, padded to an even width for two bits per root step.
   localparam int DISC_W    = 70;
   localparam int ROOT_W    = DISC_W / 2;
   localparam int SQ_REM_W  = ROOT_W + 3;

   // Magnitude of -b +/- sqrt(D) before the fraction shift.
   localparam int NUM_MAG_W = 34;

   // Divisor 2*|a| and the partial remainder of the divider.
   localparam int DEN_W     = COEF_W + 1;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NEG_DISC = 2'd1;
   localparam logic [1:0] STATUS_A_ZERO   = 2'd2;
   localparam logic [1:0] STATUS_SAT      = 2'd3;

   // Side data that travels with each request down the pipeline.
   typedef struct packed {
      logic              a_zero;
      logic              d_neg;
      logic              a_neg;
      logic              b_neg;
      logic [COEF_W-1:0] a_mag;
      logic [COEF_W-1:0] b_mag;
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/quadratic_root_solver_core.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Solves a*x^2 + b*x + c = 0 in signed fixed point: exact discriminant,
// pipelined floor square root, two pipelined restoring dividers, saturation.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Ports                                  | Handshake
//  ---------+-----------+----------------------------------------+-----------
//  request  | in        | req_coef_a, req_coef_b, req_coef_c     | valid/ready
//  response | out       | rsp_root_plus, rsp_root_minus,         | valid/ready
//           |           | rsp_status                             |
//
//  One request enters per cycle while the pipeline advances. Its stages are
//  three stages for operands, products and discriminant, 35 square-root
//  stages, one numerator stage, one divider stage per quotient bit, and the
//  output register. The whole pipeline advances whenever the output register
//  is empty or the response is taken, so a stall freezes every stage.
//  Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_core #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] req_coef_a,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] req_coef_b,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] req_coef_c,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic signed [qrs_pkg::COEF_W-1:0] rsp_root_plus,
   output      logic signed [qrs_pkg::COEF_W-1:0] rsp_root_minus,
   output      logic        [1:0]                 rsp_status
);

   localparam int CW     = qrs_pkg::COEF_W;
   localparam int DW     = qrs_pkg::DISC_W;
   localparam int RW     = qrs_pkg::ROOT_W;
   localparam int SW     = qrs_pkg::SQ_REM_W;
   localparam int NW     = qrs_pkg::NUM_MAG_W + FRAC_BITS;
   localparam int EW     = qrs_pkg::DEN_W;
   localparam int ST_SQ  = 2;
   localparam int ST_NUM = ST_SQ + RW + 1;
   localparam int LAST   = ST_NUM + NW + 1;

   // Pipeline advance: everything moves when the output slot frees up.
   logic adv;
   logic [LAST:0] v_ff;
   qrs_pkg::ctl_type ctl_ff [0:LAST];
   qrs_pkg::ctl_type ctl_in [0:LAST];

   assign adv       = !v_ff[LAST] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = v_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAST-1:0], req_valid};
      end
   end

   // Stage 0: operand magnitudes and signs.
   logic [CW-1:0]    c_mag_ff;
   logic             c_neg_ff;
   qrs_pkg::ctl_type op_in;

   always_comb begin
      op_in.a_neg  = req_coef_a[CW-1];
      op_in.b_neg  = req_coef_b[CW-1];
      op_in.a_mag  = req_coef_a[CW-1] ? (~req_coef_a + 1'b1) : req_coef_a;
      op_in.b_mag  = req_coef_b[CW-1] ? (~req_coef_b + 1'b1) : req_coef_b;
      op_in.a_zero = (req_coef_a == '0);
      op_in.d_neg  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_neg_ff <= req_coef_c[CW-1];
         c_mag_ff <= req_coef_c[CW-1] ? (~req_coef_c + 1'b1) : req_coef_c;
      end
   end

   // Stage 1: b*b and a*c on the magnitudes.
   logic [2*CW-1:0] bb_ff;
   logic [2*CW-1:0] ac_ff;
   logic            c_neg1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         bb_ff     <= ctl_ff[0].b_mag * ctl_ff[0].b_mag;
         ac_ff     <= ctl_ff[0].a_mag * c_mag_ff;
         c_neg1_ff <= c_neg_ff;
      end
   end

   // Stage 2: discriminant b*b -/+ 4*a*c, with the negative case flagged.
   logic [2*CW+2:0] ac4;
   logic [2*CW+2:0] bb_x;
   logic [DW-1:0]   d_in;
   logic [DW-1:0]   d_ff;
   logic            same_sign;

   always_comb begin
      ac4       = {1'b0, ac_ff, 2'b00};
      bb_x      = {3'b000, bb_ff};
      same_sign = (ctl_ff[1].a_neg == c_neg1_ff);
      d_in      = {{(DW-2*CW-3){1'b0}}, (same_sign ? (bb_x - ac4) : (bb_x + ac4))};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
      end
   end

   // Side data moves with its request; the discriminant stage sets its flag.
   always_comb begin
      ctl_in[0] = op_in;
      for (int k = 1; k <= LAST; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      ctl_in[ST_SQ].d_neg = same_sign && (bb_x < ac4);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= LAST; k++) begin
            ctl_ff[k] <= ctl_in[k];
         end
      end
   end

   // Square root: one result bit per stage from two discriminant bits.
   logic [SW-1:0] sq_rem_ff  [1:RW];
   logic [RW-1:0] sq_root_ff [1:RW];
   logic [DW-1:0] sq_d_ff    [1:RW];
   logic [SW-1:0] sq_rem_in  [1:RW];
   logic [RW-1:0] sq_root_in [1:RW];
   logic [DW-1:0] sq_d_in    [1:RW];

   always_comb begin
      logic [SW-1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [DW-1:0] d_prev;
      logic [SW-1:0] rem_try;
      logic [SW-1:0] trial;
      for (int j = 1; j <= RW; j++) begin
         rem_prev  = (j == 1) ? '0 : sq_rem_ff[(j == 1) ? 1 : j-1];
         root_prev = (j == 1) ? '0 : sq_root_ff[(j == 1) ? 1 : j-1];
         d_prev    = (j == 1) ? d_ff : sq_d_ff[(j == 1) ? 1 : j-1];
         rem_try   = {rem_prev[SW-3:0], d_prev[DW-1:DW-2]};
         trial     = {{(SW-RW-2){1'b0}}, root_prev, 2'b01};
         if (rem_try >= trial) begin
            sq_rem_in[j]  = rem_try - trial;
            sq_root_in[j] = {root_prev[RW-2:0], 1'b1};
         end else begin
            sq_rem_in[j]  = rem_try;
            sq_root_in[j] = {root_prev[RW-2:0], 1'b0};
         end
         sq_d_in[j] = {d_prev[DW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 1; j <= RW; j++) begin
            sq_rem_ff[j]  <= sq_rem_in[j];
            sq_root_ff[j] <= sq_root_in[j];
            sq_d_ff[j]    <= sq_d_in[j];
         end
      end
   end

   // Numerators -b + s and -b - s as magnitude, sign and shifted dividend.
   logic signed [RW:0] nb;
   logic signed [RW:0] sq_s;
   logic signed [RW:0] num_p;
   logic signed [RW:0] num_m;
   logic [NW-1:0]      dv_n_ff   [0:1];
   logic               dv_neg_ff [0:1];
   logic [EW-1:0]      den_ff;

   always_comb begin
      nb    = ctl_ff[ST_NUM-1].b_neg ? $signed({{(RW+1-CW){1'b0}}, ctl_ff[ST_NUM-1].b_mag})
                                     : -$signed({{(RW+1-CW){1'b0}}, ctl_ff[ST_NUM-1].b_mag});
      sq_s  = $signed({1'b0, sq_root_ff[RW]});
      num_p = nb + sq_s;
      num_m = nb - sq_s;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_neg_ff[0] <= num_p[RW] ^ ctl_ff[ST_NUM-1].a_neg;
         dv_neg_ff[1] <= num_m[RW] ^ ctl_ff[ST_NUM-1].a_neg;
         dv_n_ff[0]   <= {(num_p[RW] ? (~num_p[NW-FRAC_BITS-1:0] + 1'b1)
                                     : num_p[NW-FRAC_BITS-1:0]), {FRAC_BITS{1'b0}}};
         dv_n_ff[1]   <= {(num_m[RW] ? (~num_m[NW-FRAC_BITS-1:0] + 1'b1)
                                     : num_m[NW-FRAC_BITS-1:0]), {FRAC_BITS{1'b0}}};
         den_ff       <= {ctl_ff[ST_NUM-1].a_mag, 1'b0};
      end
   end

   // Two restoring dividers, one quotient bit per stage.
   logic [NW-1:0] qd_n_ff   [0:1][1:NW];
   logic [EW-1:0] qd_rem_ff [0:1][1:NW];
   logic [NW-1:0] qd_q_ff   [0:1][1:NW];
   logic          qd_neg_ff [0:1][1:NW];
   logic [EW-1:0] qd_den_ff [1:NW];
   logic [NW-1:0] qd_n_in   [0:1][1:NW];
   logic [EW-1:0] qd_rem_in [0:1][1:NW];
   logic [NW-1:0] qd_q_in   [0:1][1:NW];

   always_comb begin
      logic [NW-1:0] n_prev;
      logic [EW-1:0] rem_prev;
      logic [NW-1:0] q_prev;
      logic [EW-1:0] den_prev;
      logic [EW:0]   rem_try;
      for (int u = 0; u < 2; u++) begin
         for (int j = 1; j <= NW; j++) begin
            n_prev   = (j == 1) ? dv_n_ff[u] : qd_n_ff[u][(j == 1) ? 1 : j-1];
            rem_prev = (j == 1) ? '0 : qd_rem_ff[u][(j == 1) ? 1 : j-1];
            q_prev   = (j == 1) ? '0 : qd_q_ff[u][(j == 1) ? 1 : j-1];
            den_prev = (j == 1) ? den_ff : qd_den_ff[(j == 1) ? 1 : j-1];
            rem_try  = {rem_prev, n_prev[NW-1]};
            if (rem_try >= {1'b0, den_prev}) begin
               qd_rem_in[u][j] = EW'(rem_try - {1'b0, den_prev});
               qd_q_in[u][j]   = {q_prev[NW-2:0], 1'b1};
            end else begin
               qd_rem_in[u][j] = rem_try[EW-1:0];
               qd_q_in[u][j]   = {q_prev[NW-2:0], 1'b0};
            end
            qd_n_in[u][j] = {n_prev[NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 1; j <= NW; j++) begin
            qd_den_ff[j] <= (j == 1) ? den_ff : qd_den_ff[(j == 1) ? 1 : j-1];
            for (int u = 0; u < 2; u++) begin
               qd_n_ff[u][j]   <= qd_n_in[u][j];
               qd_rem_ff[u][j] <= qd_rem_in[u][j];
               qd_q_ff[u][j]   <= qd_q_in[u][j];
               qd_neg_ff[u][j] <= (j == 1) ? dv_neg_ff[u]
                                           : qd_neg_ff[u][(j == 1) ? 1 : j-1];
            end
         end
      end
   end

   // Output stage: saturation, sign and status.
   logic [CW-1:0] root_in [0:1];
   logic          sat_in  [0:1];
   logic [CW-1:0] root_ff [0:1];
   logic [1:0]    status_in;
   logic [1:0]    status_ff;

   always_comb begin
      logic [NW-1:0] lim;
      logic [NW-1:0] q;
      for (int u = 0; u < 2; u++) begin
         q   = qd_q_ff[u][NW];
         lim = qd_neg_ff[u][NW] ? (NW'(1) << (CW-1)) : ((NW'(1) << (CW-1)) - 1'b1);
         sat_in[u] = (q > lim);
         if (sat_in[u]) begin
            q = lim;
         end
         root_in[u] = qd_neg_ff[u][NW] ? (~q[CW-1:0] + 1'b1) : q[CW-1:0];
      end
      if (ctl_ff[LAST-1].a_zero) begin
         status_in  = qrs_pkg::STATUS_A_ZERO;
         root_in[0] = '0;
         root_in[1] = '0;
      end else if (ctl_ff[LAST-1].d_neg) begin
         status_in  = qrs_pkg::STATUS_NEG_DISC;
         root_in[0] = '0;
         root_in[1] = '0;
      end else if (sat_in[0] || sat_in[1]) begin
         status_in = qrs_pkg::STATUS_SAT;
      end else begin
         status_in = qrs_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff[0] <= root_in[0];
         root_ff[1] <= root_in[1];
         status_ff  <= status_in;
      end
   end

   assign rsp_root_plus  = $signed(root_ff[0]);
   assign rsp_root_minus = $signed(root_ff[1]);
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire
